FILE: rtl/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg
// shared types, widths and coefficient tables of the legendre evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package lpe_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_DEGREE_DEF = 8;
  localparam int TOP_DEGREE     = 8;   // last row held in the tables

  localparam int POINT_W  = 18;
  localparam int RESULT_W = 23;
  localparam int DEG_W    = 4;
  localparam int COEF_W   = 18;
  localparam int NCOEF    = 9;
  localparam int SHIFT_W  = 3;

  // accumulator saturates at +-(2^(ACC_W-1) - 1)
  localparam int    ACC_W   = 47;
  localparam longint ACC_LIM = (longint'(1) <<< (ACC_W - 1)) - longint'(1);

  // the accumulator multiply is split into a low unsigned and a high signed slice
  localparam int LO_W  = 24;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int LO_PW = LO_W + 1 + POINT_W;
  localparam int HI_PW = HI_W + POINT_W;

  localparam logic ACTION_VALUE = 1'b0;
  localparam logic ACTION_DERIV = 1'b1;

  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [POINT_W-1:0] point_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef struct packed {
    logic             action;
    logic [DEG_W-1:0] degree;
    logic             bad;
  } lpe_tag_t;

  // coefficients c0..c8, one row per degree
  localparam int VAL_COEF [NCOEF][NCOEF] = '{
    '{1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{-1, 0, 3, 0, 0, 0, 0, 0, 0},
    '{0, -3, 0, 5, 0, 0, 0, 0, 0},
    '{3, 0, -30, 0, 35, 0, 0, 0, 0},
    '{0, 15, 0, -70, 0, 63, 0, 0, 0},
    '{-5, 0, 105, 0, -315, 0, 231, 0, 0},
    '{0, -35, 0, 315, 0, -693, 0, 429, 0},
    '{35, 0, -1260, 0, 6930, 0, -12012, 0, 6435}
  };

  localparam int DER_COEF [NCOEF][NCOEF] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 3, 0, 0, 0, 0, 0, 0, 0},
    '{-3, 0, 15, 0, 0, 0, 0, 0, 0},
    '{0, -60, 0, 140, 0, 0, 0, 0, 0},
    '{15, 0, -210, 0, 315, 0, 0, 0, 0},
    '{0, 210, 0, -1260, 0, 1386, 0, 0, 0},
    '{-35, 0, 945, 0, -3465, 0, 3003, 0, 0},
    '{0, -2520, 0, 27720, 0, -72072, 0, 51480, 0}
  };

  // log2 of the power-of-two divisor of each row
  localparam int VAL_SHIFT [NCOEF] = '{0, 0, 1, 1, 3, 3, 4, 4, 7};
  localparam int DER_SHIFT [NCOEF] = '{0, 0, 0, 1, 3, 3, 4, 4, 7};

  function automatic coef_t coef(input logic action, input logic [DEG_W-1:0] degree,
                                 input logic [DEG_W-1:0] k);
    coef_t c;
    c = '0;
    if (degree <= DEG_W'(TOP_DEGREE)) begin
      if (action == ACTION_DERIV) begin
        c = COEF_W'(DER_COEF[degree][k]);
      end else begin
        c = COEF_W'(VAL_COEF[degree][k]);
      end
    end
    return c;
  endfunction

  function automatic logic [SHIFT_W-1:0] div_shift(input logic action,
                                                   input logic [DEG_W-1:0] degree);
    logic [SHIFT_W-1:0] s;
    s = '0;
    if (degree <= DEG_W'(TOP_DEGREE)) begin
      if (action == ACTION_DERIV) begin
        s = SHIFT_W'(DER_SHIFT[degree]);
      end else begin
        s = SHIFT_W'(VAL_SHIFT[degree]);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lpe_step.sv
// ----------------------------------------------------------------------------
// lpe_step
// one horner step over two register stages: split multiply, then round and add
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_step #(
  parameter int FRAC_BITS = lpe_pkg::FRAC_BITS_DEF,
  parameter int STEP      = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lpe_pkg::lpe_tag_t in_tag,
  input  wire lpe_pkg::acc_t     in_acc,
  input  wire lpe_pkg::point_t   in_x,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lpe_pkg::lpe_tag_t      out_tag,
  output lpe_pkg::acc_t          out_acc,
  output lpe_pkg::point_t        out_x
);

  localparam int LO_PW = lpe_pkg::LO_PW;
  localparam int HI_PW = lpe_pkg::HI_PW;
  localparam int SUM_W = lpe_pkg::ACC_W + lpe_pkg::POINT_W + 1;
  localparam logic signed [LO_PW:0]     HALF   = (LO_PW + 1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]   LIM_HI = SUM_W'(lpe_pkg::ACC_LIM);
  localparam logic signed [SUM_W-1:0]   LIM_LO = -LIM_HI;

  // stage a: partial products
  logic                     a_valid;
  logic                     a_ready;
  lpe_pkg::lpe_tag_t        a_tag;
  lpe_pkg::point_t          a_x;
  logic signed [LO_PW:0]    a_lo;
  logic signed [HI_PW-1:0]  a_hi;

  logic signed [LO_PW-1:0]  lo_prod;
  logic signed [HI_PW-1:0]  hi_prod;

  logic                     b_ready;

  assign lo_prod = $signed({1'b0, in_acc[lpe_pkg::LO_W-1:0]}) * in_x;
  assign hi_prod = $signed(in_acc[lpe_pkg::ACC_W-1:lpe_pkg::LO_W]) * in_x;

  assign a_ready  = ~a_valid | b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_tag <= in_tag;
      a_x   <= in_x;
      // rounding half folded into the low slice
      a_lo  <= (LO_PW + 1)'(lo_prod) + HALF;
      a_hi  <= hi_prod;
    end
  end

  // stage b: recombine, round, add coefficient, saturate
  lpe_pkg::coef_t           c;
  logic signed [SUM_W-1:0]  full;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sat;

  always_comb begin
    c    = lpe_pkg::coef(a_tag.action, a_tag.degree, lpe_pkg::DEG_W'(STEP));
    full = (SUM_W'(a_hi) <<< lpe_pkg::LO_W) + SUM_W'(a_lo);
    rnd  = full >>> FRAC_BITS;
    sum  = rnd + (SUM_W'(c) <<< FRAC_BITS);
    if (sum > LIM_HI) begin
      sat = LIM_HI;
    end else if (sum < LIM_LO) begin
      sat = LIM_LO;
    end else begin
      sat = sum;
    end
  end

  assign b_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      out_tag <= a_tag;
      out_x   <= a_x;
      out_acc <= sat[lpe_pkg::ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lpe_final.sv
// ----------------------------------------------------------------------------
// lpe_final
// divisor rounding, result saturation and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_final #(
  parameter int FRAC_BITS = lpe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lpe_pkg::lpe_tag_t             in_tag,
  input  wire lpe_pkg::acc_t                 in_acc,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lpe_pkg::RESULT_W-1:0]       result,
  output logic                               bad_degree
);

  localparam int RW = lpe_pkg::ACC_W + 1;
  localparam logic signed [RW-1:0] RES_HI = RW'(36) <<< FRAC_BITS;
  localparam logic signed [RW-1:0] RES_LO = -RES_HI;

  logic [lpe_pkg::SHIFT_W-1:0] sh;
  logic signed [RW-1:0]        v;
  logic signed [RW-1:0]        r;
  logic signed [RW-1:0]        sat;

  always_comb begin
    sh = lpe_pkg::div_shift(in_tag.action, in_tag.degree);
    v  = RW'(in_acc);
    if (sh == '0) begin
      r = v;
    end else begin
      r = (v + (RW'(1) <<< (sh - lpe_pkg::SHIFT_W'(1)))) >>> sh;
    end
    if (r > RES_HI) begin
      sat = RES_HI;
    end else if (r < RES_LO) begin
      sat = RES_LO;
    end else begin
      sat = r;
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      bad_degree <= in_tag.bad;
      result     <= in_tag.bad ? '0 : sat[lpe_pkg::RESULT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/legendre_poly_eval_unit.sv
// ----------------------------------------------------------------------------
// legendre_poly_eval_unit
// pipelined legendre polynomial and derivative evaluator, degrees 0 to 8
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled, and returns one
// beat per input beat, in order. An accepted input beat passes through one
// load stage that seeds the accumulator with the leading coefficient, eight
// horner steps of two stages each (the 47-bit accumulator times the 18-bit
// point is formed as two narrow partial products, then recombined, rounded
// and added to the next coefficient), and one output stage that applies
// the row's power-of-two divisor and saturates. Every stage has its own
// valid bit and local ready, so bubbles are squeezed out and the input
// keeps taking beats while a finished result waits. Point and result are
// signed fixed point with FRAC_BITS fraction bits; a degree above
// MAX_DEGREE gives a zero result with bad_degree set.
// ----------------------------------------------------------------------------
`default_nettype none

module legendre_poly_eval_unit #(
  parameter int FRAC_BITS  = lpe_pkg::FRAC_BITS_DEF,
  parameter int MAX_DEGREE = lpe_pkg::MAX_DEGREE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [3:0] degree, [21:4] point, [23:22] zero
  input  wire logic        s_tuser,   // [0] action: 0 value, 1 derivative
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [22:0] result, [23] zero
  output logic             m_tuser    // [0] bad_degree
);

  localparam int NSTEP = lpe_pkg::NCOEF - 1;

  // unpack the input beat
  logic [lpe_pkg::DEG_W-1:0] in_degree;
  lpe_pkg::point_t           in_point;
  lpe_pkg::coef_t            c_top;

  assign in_degree = s_tdata[lpe_pkg::DEG_W-1:0];
  assign in_point  = s_tdata[lpe_pkg::DEG_W +: lpe_pkg::POINT_W];
  assign c_top     = lpe_pkg::coef(s_tuser, in_degree, lpe_pkg::DEG_W'(NSTEP));

  // chain nodes: node 0 is the load stage, node i+1 the output of step i
  logic                   node_valid [NSTEP+1];
  logic                   node_ready [NSTEP+1];
  lpe_pkg::lpe_tag_t      node_tag   [NSTEP+1];
  lpe_pkg::acc_t          node_acc   [NSTEP+1];
  lpe_pkg::point_t        node_x     [NSTEP+1];

  logic load_ready;

  // load stage registers
  logic                   load_valid;
  lpe_pkg::lpe_tag_t      load_tag;
  lpe_pkg::acc_t          load_acc;
  lpe_pkg::point_t        load_x;

  // load stage: accumulator starts at the leading coefficient, scaled
  assign load_ready = ~load_valid | node_ready[0];
  assign s_tready   = load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_valid <= 1'b0;
    end else if (load_ready) begin
      load_valid <= s_tvalid;
    end
    if (load_ready && s_tvalid) begin
      load_tag.action <= s_tuser;
      load_tag.degree <= in_degree;
      load_tag.bad    <= in_degree > lpe_pkg::DEG_W'(MAX_DEGREE);
      load_x          <= in_point;
      load_acc        <= lpe_pkg::ACC_W'(c_top) <<< FRAC_BITS;
    end
  end

  assign node_valid[0] = load_valid;
  assign node_tag[0]   = load_tag;
  assign node_acc[0]   = load_acc;
  assign node_x[0]     = load_x;

  // horner steps, coefficient index counts down from seven to zero
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    lpe_step #(
      .FRAC_BITS (FRAC_BITS),
      .STEP      (NSTEP - 1 - i)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (node_valid[i]),
      .in_ready  (node_ready[i]),
      .in_tag    (node_tag[i]),
      .in_acc    (node_acc[i]),
      .in_x      (node_x[i]),
      .out_valid (node_valid[i+1]),
      .out_ready (node_ready[i+1]),
      .out_tag   (node_tag[i+1]),
      .out_acc   (node_acc[i+1]),
      .out_x     (node_x[i+1])
    );
  end

  // divisor, saturation and output register
  logic [lpe_pkg::RESULT_W-1:0] result;
  logic                         bad_degree;

  lpe_final #(
    .FRAC_BITS (FRAC_BITS)
  ) u_final (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (node_valid[NSTEP]),
    .in_ready   (node_ready[NSTEP]),
    .in_tag     (node_tag[NSTEP]),
    .in_acc     (node_acc[NSTEP]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result),
    .bad_degree (bad_degree)
  );

  assign m_tdata = {1'b0, result};
  assign m_tuser = bad_degree;

  // a rejected degree always leaves as a zero result
  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[lpe_pkg::RESULT_W-1:0] == '0)
    else $error("bad degree beat carries a nonzero result");

  // the input only backs up when the whole pipe is full behind a stalled output
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without an output stall");

  // for any degree other than the top degree the leading coefficient is zero, so the seed is zero
  a_seed_zero : assert property (@(posedge clk) disable iff (rst)
    node_valid[0] && node_tag[0].degree != lpe_pkg::DEG_W'(lpe_pkg::TOP_DEGREE)
      |-> node_acc[0] == '0)
    else $error("nonzero accumulator seed below the top degree");

endmodule

`default_nettype wire
